// ===== hdl/s2y_pkg.sv =====
`timescale 1ns / 1ps

package s2y_pkg;

  // field widths
  localparam int IN_W   = 24;
  localparam int OUT_W  = 32;
  localparam int ADM_W  = 24;
  localparam int FRAC_W = 20;

  // datapath widths
  localparam int EXT_W   = IN_W + 1;
  localparam int P1_W    = 2 * EXT_W;
  localparam int OP_W    = 52;
  localparam int HALF_W  = OP_W / 2;
  localparam int PROD_W  = 2 * OP_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int DEN_W   = PROD_W;
  localparam int SLICE_W = 26;
  localparam int SLICES  = MAG_W / SLICE_W;
  localparam int SP_W    = SLICE_W + ADM_W;
  localparam int A_W     = 128;
  localparam int Q_W     = 33;
  localparam int SAT_SHIFT = 31;

  localparam int LANES    = 8;
  localparam int PAIRS    = 4;
  localparam int NUM_MULS = 2 + 4 * PAIRS;

  // stage counts
  localparam int FRONT_LAT = 2;
  localparam int MUL_LAT   = 4;
  localparam int SCALE_LAT = 3;
  localparam int DIV_LAT   = Q_W + 3;
  localparam int PIPE_LAT  = FRONT_LAT + MUL_LAT + 1 + SCALE_LAT + DIV_LAT + 1;
  localparam int SING_DLY  = SCALE_LAT + DIV_LAT;

  localparam logic [ADM_W-1:0] ADM_RESET = 24'd335544;

  typedef logic signed [IN_W-1:0]   s_t;
  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic signed [P1_W-1:0]   p1_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [A_W-1:0]           acc_t;
  typedef logic signed [OUT_W-1:0]  y_t;

  localparam ext_t ONE   = ext_t'(1 << FRAC_W);
  localparam y_t   Y_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam y_t   Y_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    s_t s11_real;
    s_t s11_imag;
    s_t s12_real;
    s_t s12_imag;
    s_t s21_real;
    s_t s21_imag;
    s_t s22_real;
    s_t s22_imag;
  } sparam_t;

  typedef struct packed {
    op_t              dr;
    op_t              di;
    op_t [PAIRS-1:0]  nr;
    op_t [PAIRS-1:0]  ni;
  } front_t;

  typedef struct packed {
    y_t [LANES-1:0] y;
    logic           saturated;
    logic           singular;
  } res_t;

  function automatic ext_t sx1(input s_t x);
    return {x[IN_W-1], x};
  endfunction

  function automatic op_t ox(input p1_t p);
    return {{(OP_W-P1_W){p[P1_W-1]}}, p};
  endfunction

endpackage

// ===== hdl/s2y_front.sv =====
`timescale 1ns / 1ps

module s2y_front import s2y_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  sparam_t s,
  output front_t  f
);

  ext_t d1r, d1i, d2r, d2i, m1r, m1i, m2r, m2i;
  ext_t a12r, a12i, a21r, a21i;
  p1_t  pp [16];
  s_t   s12r_q, s12i_q, s21r_q, s21i_q;
  op_t  pr, pi;

  always_comb begin
    d1r  = ONE + sx1(s.s11_real);
    d1i  = sx1(s.s11_imag);
    d2r  = ONE + sx1(s.s22_real);
    d2i  = sx1(s.s22_imag);
    m1r  = ONE - sx1(s.s11_real);
    m1i  = -sx1(s.s11_imag);
    m2r  = ONE - sx1(s.s22_real);
    m2i  = -sx1(s.s22_imag);
    a12r = sx1(s.s12_real);
    a12i = sx1(s.s12_imag);
    a21r = sx1(s.s21_real);
    a21i = sx1(s.s21_imag);
  end

  // first stage: all narrow products
  always_ff @(posedge clk) begin
    if (en) begin
      pp[0]  <= a12r * a21r;
      pp[1]  <= a12i * a21i;
      pp[2]  <= a12r * a21i;
      pp[3]  <= a12i * a21r;
      pp[4]  <= d1r * d2r;
      pp[5]  <= d1i * d2i;
      pp[6]  <= d1r * d2i;
      pp[7]  <= d1i * d2r;
      pp[8]  <= d2r * m1r;
      pp[9]  <= d2i * m1i;
      pp[10] <= d2r * m1i;
      pp[11] <= d2i * m1r;
      pp[12] <= d1r * m2r;
      pp[13] <= d1i * m2i;
      pp[14] <= d1r * m2i;
      pp[15] <= d1i * m2r;
      s12r_q <= s.s12_real;
      s12i_q <= s.s12_imag;
      s21r_q <= s.s21_real;
      s21i_q <= s.s21_imag;
    end
  end

  // s12*s21
  always_comb begin
    pr = ox(pp[0]) - ox(pp[1]);
    pi = ox(pp[2]) + ox(pp[3]);
  end

  // second stage: delta and the four numerators
  always_ff @(posedge clk) begin
    if (en) begin
      f.dr    <= ox(pp[4]) - ox(pp[5]) - pr;
      f.di    <= ox(pp[6]) + ox(pp[7]) - pi;
      f.nr[0] <= ox(pp[8]) - ox(pp[9]) + pr;
      f.ni[0] <= ox(pp[10]) + ox(pp[11]) + pi;
      f.nr[1] <= -(op_t'(s12r_q) <<< (FRAC_W + 1));
      f.ni[1] <= -(op_t'(s12i_q) <<< (FRAC_W + 1));
      f.nr[2] <= -(op_t'(s21r_q) <<< (FRAC_W + 1));
      f.ni[2] <= -(op_t'(s21i_q) <<< (FRAC_W + 1));
      f.nr[3] <= ox(pp[12]) - ox(pp[13]) + pr;
      f.ni[3] <= ox(pp[14]) + ox(pp[15]) + pi;
    end
  end

endmodule

// ===== hdl/s2y_mul.sv =====
`timescale 1ns / 1ps

module s2y_mul import s2y_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  op_t   a,
  input  op_t   b,
  output prod_t p
);

  logic [OP_W-1:0]   ma, mb;
  logic              sg1, sg2, sg3;
  logic [OP_W-1:0]   pp [4];
  logic [PROD_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      // sign and magnitude
      ma  <= a[OP_W-1] ? (~a + OP_W'(1)) : a;
      mb  <= b[OP_W-1] ? (~b + OP_W'(1)) : b;
      sg1 <= a[OP_W-1] ^ b[OP_W-1];
      // four half-width partial products
      pp[0] <= ma[HALF_W-1:0] * mb[HALF_W-1:0];
      pp[1] <= ma[HALF_W-1:0] * mb[OP_W-1:HALF_W];
      pp[2] <= ma[OP_W-1:HALF_W] * mb[HALF_W-1:0];
      pp[3] <= ma[OP_W-1:HALF_W] * mb[OP_W-1:HALF_W];
      sg2   <= sg1;
      sum   <= PROD_W'(pp[0]) + (PROD_W'(pp[1]) << HALF_W)
             + (PROD_W'(pp[2]) << HALF_W) + (PROD_W'(pp[3]) << OP_W);
      sg3   <= sg2;
      p     <= sg3 ? -prod_t'(sum) : prod_t'(sum);
    end
  end

endmodule

// ===== hdl/s2y_scale.sv =====
`timescale 1ns / 1ps

module s2y_scale import s2y_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ADM_W-1:0]      y0,
  input  num_t [LANES-1:0]      num,
  output acc_t [LANES-1:0]      a,
  output logic [LANES-1:0]      neg
);

  logic [MAG_W-1:0]             mag [LANES];
  logic [SLICES-1:0][SP_W-1:0]  sp  [LANES];
  logic [LANES-1:0]             neg1, neg2;
  acc_t                         acc [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      acc[l] = '0;
      for (int j = 0; j < SLICES; j++) begin
        acc[l] = acc[l] + (A_W'(sp[l][j]) << (j * SLICE_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= num[l][NUM_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
        for (int j = 0; j < SLICES; j++) begin
          sp[l][j] <= mag[l][j*SLICE_W +: SLICE_W] * y0;
        end
        a[l] <= acc[l];
      end
      neg1 <= {num[7][NUM_W-1], num[6][NUM_W-1], num[5][NUM_W-1], num[4][NUM_W-1],
               num[3][NUM_W-1], num[2][NUM_W-1], num[1][NUM_W-1], num[0][NUM_W-1]};
      neg2 <= neg1;
      neg  <= neg2;
    end
  end

endmodule

// ===== hdl/s2y_div.sv =====
`timescale 1ns / 1ps

module s2y_div import s2y_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  acc_t [LANES-1:0]   a,
  input  logic [LANES-1:0]   neg,
  input  den_t               den,
  output y_t   [LANES-1:0]   y,
  output logic               sat
);

  acc_t             a1    [LANES];
  acc_t             diff1 [LANES];
  logic [LANES-1:0] ge1, neg1;
  den_t             den1;
  logic [A_W:0]     diff_full [LANES];

  den_t             den_s [0:Q_W];
  logic [LANES-1:0] neg_s [0:Q_W];
  logic [LANES-1:0] sat_s [0:Q_W];
  den_t             rem_s [0:Q_W][LANES];
  logic [Q_W-1:0]   low_s [0:Q_W][LANES];
  logic [Q_W-1:0]   q_s   [0:Q_W][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff_full[l] = (A_W+1)'(a[l]) - (A_W+1)'(den);
    end
  end

  // overflow screen, then seed the remainder with the top bits
  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= den;
      neg1 <= neg;
      for (int l = 0; l < LANES; l++) begin
        a1[l]    <= a[l];
        diff1[l] <= diff_full[l][A_W-1:0];
        ge1[l]   <= !diff_full[l][A_W];
      end
      den_s[0] <= den1;
      neg_s[0] <= neg1;
      for (int l = 0; l < LANES; l++) begin
        sat_s[0][l] <= neg1[l]
                     ? (ge1[l] && ((diff1[l] >> SAT_SHIFT) >= A_W'(den1)))
                     : ((a1[l] >> SAT_SHIFT) >= A_W'(den1));
        rem_s[0][l] <= DEN_W'(a1[l] >> Q_W);
        low_s[0][l] <= a1[l][Q_W-1:0];
        q_s[0][l]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 1; s <= Q_W; s++) begin : g_step
    logic [DEN_W:0]   part  [LANES];
    logic [DEN_W+1:0] trial [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l]  = {rem_s[s-1][l], low_s[s-1][l][Q_W-1]};
        trial[l] = {1'b0, part[l]} - {2'b00, den_s[s-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[s] <= den_s[s-1];
        neg_s[s] <= neg_s[s-1];
        sat_s[s] <= sat_s[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_s[s][l] <= trial[l][DEN_W+1] ? part[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
          low_s[s][l] <= low_s[s-1][l] << 1;
          q_s[s][l]   <= {q_s[s-1][l][Q_W-2:0], !trial[l][DEN_W+1]};
        end
      end
    end
  end

  // sign and clipping
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        if (sat_s[Q_W][l]) begin
          y[l] <= neg_s[Q_W][l] ? Y_MIN : Y_MAX;
        end else begin
          y[l] <= neg_s[Q_W][l] ? -y_t'(q_s[Q_W][l][OUT_W-1:0])
                                : y_t'(q_s[Q_W][l][OUT_W-1:0]);
        end
      end
      sat <= |sat_s[Q_W];
    end
  end

endmodule

// ===== hdl/two_port_s_to_y_conversion_unit.sv =====
`timescale 1ns / 1ps

// two-port s-parameter to y-parameter converter
// s_axis carries one frequency point: eight signed q4.20 values (s11..s22,
// real then imaginary). m_axis returns the matching y11..y22 in signed
// q8.24 plus two flags in tuser: singular (delta is zero, all y are zero)
// and saturated (some component was clipped).
// cfg_* writes the reference admittance 1/z0 (unsigned q0.24); write it only
// while no point is in flight.
// throughput: one point per cycle while the skid register is free, fully pipelined.
// the datapath runs through two front stages (narrow products, then delta
// and numerators), four-stage split 52x52 multipliers, a three-stage
// admittance scaler and the restoring divider, whose bulk is 33 stages
// (one quotient bit per stage, eight lanes).
// reset clears all valid bits and loads 1/50 S into the admittance register.
// a stalled receiver holds m_axis; the next point leaving the pipeline lands
// in a one-entry skid register, and only then does s_axis_tready drop and the
// whole pipeline freeze. nothing is dropped or repeated.
module two_port_s_to_y_conversion_unit import s2y_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // s11_real, s11_imag, s12_real, s12_imag, s21_real, s21_imag, s22_real, s22_imag
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // y11_real, y11_imag, y12_real, y12_imag, y21_real, y21_imag, y22_real, y22_imag
  output logic [255:0] m_axis_tdata,
  // singular, saturated
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);

  logic               en;
  logic [ADM_W-1:0]   y0;
  logic [PIPE_LAT-1:0] vpipe;
  sparam_t            sp;
  front_t             f;

  op_t                mul_a [NUM_MULS];
  op_t                mul_b [NUM_MULS];
  prod_t              mul_p [NUM_MULS];

  den_t               den_sum;
  den_t               den_d  [0:SCALE_LAT];
  logic               sing_d [0:SING_DLY];
  num_t [LANES-1:0]   num_q;

  acc_t [LANES-1:0]   sc_a;
  logic [LANES-1:0]   sc_neg;
  y_t   [LANES-1:0]   dv_y;
  logic               dv_sat;

  res_t               pipe_res;
  logic               pipe_v;
  res_t               out_res;
  logic               out_valid;
  res_t               skid_res;
  logic               skid_valid;

  // the pipeline moves whenever the skid register is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;
  assign pipe_v        = vpipe[PIPE_LAT-1];

  // unpack the input transfer, lowest field first
  assign sp.s11_real = s_axis_tdata[0*IN_W +: IN_W];
  assign sp.s11_imag = s_axis_tdata[1*IN_W +: IN_W];
  assign sp.s12_real = s_axis_tdata[2*IN_W +: IN_W];
  assign sp.s12_imag = s_axis_tdata[3*IN_W +: IN_W];
  assign sp.s21_real = s_axis_tdata[4*IN_W +: IN_W];
  assign sp.s21_imag = s_axis_tdata[5*IN_W +: IN_W];
  assign sp.s22_real = s_axis_tdata[6*IN_W +: IN_W];
  assign sp.s22_imag = s_axis_tdata[7*IN_W +: IN_W];

  // admittance register and valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      y0    <= ADM_RESET;
      vpipe <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        y0 <= cfg_data;
      end
      if (en) begin
        vpipe <= {vpipe[PIPE_LAT-2:0], s_axis_tvalid};
      end
    end
  end

  // delta and numerators
  s2y_front u_front (
    .clk (clk),
    .en  (en),
    .s   (sp),
    .f   (f)
  );

  // |delta|^2 and numerator times conj(delta)
  always_comb begin
    mul_a[0] = f.dr;
    mul_b[0] = f.dr;
    mul_a[1] = f.di;
    mul_b[1] = f.di;
    for (int k = 0; k < PAIRS; k++) begin
      mul_a[2+4*k] = f.nr[k];
      mul_b[2+4*k] = f.dr;
      mul_a[3+4*k] = f.ni[k];
      mul_b[3+4*k] = f.di;
      mul_a[4+4*k] = f.ni[k];
      mul_b[4+4*k] = f.dr;
      mul_a[5+4*k] = f.nr[k];
      mul_b[5+4*k] = f.di;
    end
  end

  for (genvar m = 0; m < NUM_MULS; m++) begin : g_mul
    s2y_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (mul_a[m]),
      .b   (mul_b[m]),
      .p   (mul_p[m])
    );
  end

  assign den_sum = DEN_W'(mul_p[0]) + DEN_W'(mul_p[1]);

  // real part = nr*dr + ni*di, imaginary part = ni*dr - nr*di
  always_ff @(posedge clk) begin
    if (en) begin
      den_d[0]  <= den_sum;
      sing_d[0] <= (den_sum == '0);
      for (int k = 0; k < PAIRS; k++) begin
        num_q[2*k]   <= {mul_p[2+4*k][PROD_W-1], mul_p[2+4*k]}
                      + {mul_p[3+4*k][PROD_W-1], mul_p[3+4*k]};
        num_q[2*k+1] <= {mul_p[4+4*k][PROD_W-1], mul_p[4+4*k]}
                      - {mul_p[5+4*k][PROD_W-1], mul_p[5+4*k]};
      end
      for (int i = 1; i <= SCALE_LAT; i++) begin
        den_d[i] <= den_d[i-1];
      end
      for (int i = 1; i <= SING_DLY; i++) begin
        sing_d[i] <= sing_d[i-1];
      end
    end
  end

  // magnitude times y0
  s2y_scale u_scale (
    .clk (clk),
    .en  (en),
    .y0  (y0),
    .num (num_q),
    .a   (sc_a),
    .neg (sc_neg)
  );

  // divide by |delta|^2 with clipping
  s2y_div u_div (
    .clk (clk),
    .en  (en),
    .a   (sc_a),
    .neg (sc_neg),
    .den (den_d[SCALE_LAT]),
    .y   (dv_y),
    .sat (dv_sat)
  );

  // a singular point forces zero results and no clip flag
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_res.y         <= sing_d[SING_DLY] ? '0 : dv_y;
      pipe_res.saturated <= sing_d[SING_DLY] ? 1'b0 : dv_sat;
      pipe_res.singular  <= sing_d[SING_DLY];
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_res   <= pipe_res;
          out_valid <= pipe_v;
        end
      end else if (en && pipe_v) begin
        skid_res   <= pipe_res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.y;
  assign m_axis_tuser  = {out_res.saturated, out_res.singular};

  // the skid entry only exists behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output transfer pending");

  // a finished point meeting a stalled output must land in the skid
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    en && pipe_v && out_valid && !m_axis_tready |=> skid_valid)
    else $error("finished point lost on output stall");

  // skid fills only on a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid filled while output was free");

  // singular results carry zero data and no clip flag
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.singular |-> (out_res.y == '0) && !out_res.saturated)
    else $error("singular point with nonzero result");

endmodule

// ===== test/two_port_s_to_y_conversion_unit_test.sv =====
`timescale 1ns / 1ps

module two_port_s_to_y_conversion_unit_test import s2y_pkg::*;;

  typedef logic signed [255:0] wide_t;

  // one y-parameter result as seen on m_axis
  typedef struct {
    logic [255:0] ydata;
    logic [1:0]   flags;
  } ypoint_t;

  // one row of the directed stimulus
  typedef struct {
    logic [191:0] sdata;
    bit           typed;
    ypoint_t      want;
  } srow_t;

  localparam int DRAIN_CYCLES = PIPE_LAT + 16;
  localparam int RANDOM_PER_PHASE = 310;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // s11_real, s11_imag, s12_real, s12_imag, s21_real, s21_imag, s22_real, s22_imag
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // y11_real, y11_imag, y12_real, y12_imag, y21_real, y21_imag, y22_real, y22_imag
  logic [255:0] m_axis_tdata;
  // singular, saturated
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  logic [ADM_W-1:0] admittance = ADM_RESET;  // predictor copy of the register
  ypoint_t          pending_y[$];            // expected results, oldest first
  int               mismatches = 0;
  bit               no_idle = 1'b0;          // stretch with no gaps on either side

  two_port_s_to_y_conversion_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // generous hard limit on run length
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // y = trunc(n * conj(delta) * y0 / |delta|^2), clipped to 32 bits
  function automatic logic [31:0] scale_y(wide_t num, wide_t den, logic [ADM_W-1:0] y0,
                                          ref bit clip);
    wide_t q;
    q = (num * wide_t'(longint'(y0))) / den;
    if (q > wide_t'(64'sd2147483647)) begin
      clip = 1'b1;
      return 32'h7fffffff;
    end
    if (q < -wide_t'(64'sd2147483648)) begin
      clip = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic ypoint_t s_to_y(logic [191:0] sd, logic [ADM_W-1:0] y0);
    longint s[8];
    longint one, d1r, d1i, d2r, d2i, m1r, m1i, m2r, m2i, pr, pi, dr, di;
    longint nr[4], ni[4];
    wide_t den, re, im;
    bit clip;
    ypoint_t r;
    for (int k = 0; k < 8; k++) s[k] = longint'($signed(sd[24*k +: 24]));
    one = longint'(1) << FRAC_W;
    d1r = one + s[0]; d1i = s[1]; d2r = one + s[6]; d2i = s[7];
    m1r = one - s[0]; m1i = -s[1]; m2r = one - s[6]; m2i = -s[7];
    pr = s[2] * s[4] - s[3] * s[5];
    pi = s[2] * s[5] + s[3] * s[4];
    dr = d1r * d2r - d1i * d2i - pr;
    di = d1r * d2i + d1i * d2r - pi;
    nr[0] = d2r * m1r - d2i * m1i + pr;
    ni[0] = d2r * m1i + d2i * m1r + pi;
    nr[1] = -2 * s[2] * one; ni[1] = -2 * s[3] * one;
    nr[2] = -2 * s[4] * one; ni[2] = -2 * s[5] * one;
    nr[3] = d1r * m2r - d1i * m2i + pr;
    ni[3] = d1r * m2i + d1i * m2r + pi;
    r.ydata = '0;
    r.flags = 2'b01;
    clip = 1'b0;
    // zero delta: all y zero, singular only
    if (dr == 0 && di == 0) return r;
    den = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
    for (int k = 0; k < 4; k++) begin
      re = wide_t'(nr[k]) * wide_t'(dr) + wide_t'(ni[k]) * wide_t'(di);
      im = wide_t'(ni[k]) * wide_t'(dr) - wide_t'(nr[k]) * wide_t'(di);
      r.ydata[64*k +: 32] = scale_y(re, den, y0, clip);
      r.ydata[64*k+32 +: 32] = scale_y(im, den, y0, clip);
    end
    r.flags = {clip, 1'b0};
    return r;
  endfunction

  function automatic logic [191:0] pack_s(int a, int b, int c, int d, int e, int f,
                                          int g, int h);
    return {h[23:0], g[23:0], f[23:0], e[23:0], d[23:0], c[23:0], b[23:0], a[23:0]};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls
  initial begin
    int g;
    @(negedge clk);
    forever begin
      m_axis_tready = 1'b1;
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ypoint_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        w = pending_y.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (m_axis_tdata[32*k +: 32] !== w.ydata[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("y lane %0d: expected %h, got %h", k, w.ydata[32*k +: 32],
                       m_axis_tdata[32*k +: 32]);
          end
        end
        if (m_axis_tuser[0] !== w.flags[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("singular: expected %b, got %b", w.flags[0], m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== w.flags[1]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("saturated: expected %b, got %b", w.flags[1], m_axis_tuser[1]);
        end
      end
    end
  end

  // one s_axis transfer; called at a falling edge, returns at a falling edge
  task automatic send_point(logic [191:0] sd, bit typed, ypoint_t want);
    int g;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = sd;
    do @(posedge clk); while (!s_axis_tready);
    if (typed) begin
      pending_y.push_back(want);
    end else begin
      pending_y.push_back(s_to_y(sd, admittance));
    end
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // pause the sender until the pipeline is empty
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_y.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_admittance(logic [ADM_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    admittance = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rand_s(int mode);
    case (mode)
      0: return $urandom;                                      // full range
      1: return $signed($urandom_range(0, 2097152)) - 1048576; // passive, |s| <= 1
      default: return $signed($urandom_range(0, 8192)) - 4096; // near zero
    endcase
  endfunction

  task automatic random_points(int count);
    int v[8];
    int mode;
    ypoint_t none;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 8; k++) v[k] = rand_s(mode < 3 ? 0 : (mode < 8 ? 1 : 2));
      // singular shapes: s11 or s22 at -1 with a zero transmission term
      if (mode == 9) begin
        if ($urandom_range(0, 1)) begin
          v[0] = -1048576; v[1] = 0;
        end else begin
          v[6] = -1048576; v[7] = 0;
        end
        if ($urandom_range(0, 1)) begin
          v[2] = 0; v[3] = 0;
        end else begin
          v[4] = 0; v[5] = 0;
        end
      end
      send_point(pack_s(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]), 1'b0, none);
    end
  endtask

  initial begin
    srow_t rows[$];
    srow_t r;
    ypoint_t zero_y;
    logic [ADM_W-1:0] settings[5];
    zero_y = '{default: '0};

    // matched load: y11 = y22 = y0, nothing else
    r.sdata = '0; r.typed = 1'b1; r.want = zero_y;
    r.want.ydata[31:0] = 32'(ADM_RESET);
    r.want.ydata[223:192] = 32'(ADM_RESET);
    rows.push_back(r);
    // s11 = -1, no transmission: delta is zero
    r.sdata = pack_s(-1048576, 0, 0, 0, 0, 0, 0, 0); r.want = zero_y; r.want.flags = 2'b01;
    rows.push_back(r);
    // s22 = -1, no transmission: delta is zero
    r.sdata = pack_s(0, 0, 0, 0, 0, 0, -1048576, 0);
    rows.push_back(r);
    // all fields at the extremes
    r.typed = 1'b0;
    r.sdata = {8{24'h7fffff}}; rows.push_back(r);
    r.sdata = {8{24'h800000}}; rows.push_back(r);
    r.sdata = {8{24'hffffff}}; rows.push_back(r);
    for (int k = 0; k < 8; k++) begin
      r.sdata = '0; r.sdata[24*k +: 24] = 24'h800000; rows.push_back(r);
      r.sdata = '0; r.sdata[24*k +: 24] = 24'h7fffff; rows.push_back(r);
    end
    // open and short terminations, thru line, small near-singular delta
    r.sdata = pack_s(1048576, 0, 0, 0, 0, 0, 1048576, 0); rows.push_back(r);
    r.sdata = pack_s(0, 0, 1048576, 0, 1048576, 0, 0, 0); rows.push_back(r);
    r.sdata = pack_s(-1048575, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.sdata = pack_s(-1048576, 0, 1, 0, 1, 0, 0, 0); rows.push_back(r);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value first, directed rows
    foreach (rows[i]) send_point(rows[i].sdata, rows[i].typed, rows[i].want);
    random_points(RANDOM_PER_PHASE);

    settings[0] = '0;
    settings[1] = 24'hffffff;
    settings[2] = 24'd1;
    settings[3] = ADM_W'($urandom);
    settings[4] = ADM_RESET;
    foreach (settings[i]) begin
      drain();
      write_admittance(settings[i]);
      no_idle = (i == 3);
      random_points(RANDOM_PER_PHASE - 60);
    end
    no_idle = 1'b0;

    drain();
    if (mismatches == 0 && pending_y.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/s2y_pkg.sv
hdl/s2y_front.sv
hdl/s2y_mul.sv
hdl/s2y_scale.sv
hdl/s2y_div.sv
hdl/two_port_s_to_y_conversion_unit.sv
test/two_port_s_to_y_conversion_unit_test.sv
